[sv/mlp_pkg.sv]
// ----------------------------------------------------------------------------
// mlp_pkg
// shared types, constants and arithmetic helpers of the one-hidden-layer network
// ----------------------------------------------------------------------------
package mlp_pkg;

	localparam int MAX_HIDDEN = 16;
	localparam int HID_W = $clog2(MAX_HIDDEN);
	localparam int ACC_W = 42;

	typedef enum logic [1:0] {
		ACT_RELU    = 2'd0,
		ACT_SIGMOID = 2'd1,
		ACT_LINEAR  = 2'd2,
		ACT_LEAKY   = 2'd3
	} act_t;

	localparam logic [1:0] REG_HIDDEN_COUNT = 2'd0;
	localparam logic [1:0] REG_HIDDEN_ACT   = 2'd1;
	localparam logic [1:0] REG_OUTPUT_ACT   = 2'd2;

	localparam logic [5:0] IDX_OUTPUT_BIAS = 6'd48;

	typedef struct packed {
		logic               op;
		logic signed [15:0] sample;
		logic        [5:0]  param_index;
		logic signed [15:0] param_value;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] prediction;
		logic               saturated;
	} out_item_t;

	// floor by 12 bits (arithmetic shift floors) and saturate to 16 bits
	function automatic logic [16:0] floor_sat(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-13:0] s;
		logic [16:0] r;
		s = v[ACC_W-1:12];
		if (s > $signed((ACC_W-12)'(32767)))
			r = {16'sd32767, 1'b1};
		else if (s < -$signed((ACC_W-12)'(32768)))
			r = {16'h8000, 1'b1};
		else
			r = {s[15:0], 1'b0};
		return r;
	endfunction

	function automatic logic signed [15:0] activate(input logic signed [15:0] v,
		input act_t mode);
		logic signed [16:0] a;
		logic signed [16:0] y;
		logic signed [26:0] lk;
		logic signed [15:0] r;
		a = v[15] ? -17'(v) : 17'(v);
		if (a >= 17'sd20480)     y = 17'sd4096;
		else if (a >= 17'sd9728) y = (a >>> 5) + 17'sd3456;
		else if (a >= 17'sd4096) y = (a >>> 3) + 17'sd2560;
		else                     y = (a >>> 2) + 17'sd2048;
		lk = 27'(v) * 27'sd410;
		unique case (mode)
			ACT_RELU:    r = v[15] ? 16'sd0 : v;
			ACT_SIGMOID: r = v[15] ? 16'(17'sd4096 - y) : y[15:0];
			ACT_LINEAR:  r = v;
			default:     r = v[15] ? 16'(lk >>> 12) : v;
		endcase
		return r;
	endfunction

endpackage

[sv/mlp_if.sv]
// ----------------------------------------------------------------------------
// mlp_if
// valid/ready channel carrying one item
// ----------------------------------------------------------------------------
interface mlp_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/mlp_one_hidden_inference.sv]
// ----------------------------------------------------------------------------
// mlp_one_hidden_inference
// one-input one-output network, one hidden layer, signed q4.12 inference
// ----------------------------------------------------------------------------
// pipeline: six register stages; a sample item's result is valid in the last
// stage register and holds there until the output side takes it
// throughput: one item per cycle; a stalled result freezes every stage
// write items update the tables at acceptance and produce no result
// arst_n clears tables and valid bits and sets the configuration registers to their reset values
// ----------------------------------------------------------------------------
module mlp_one_hidden_inference (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_wdata,
	mlp_if.sink        in_ch,
	mlp_if.source      out_ch
);
	import mlp_pkg::*;

	// configuration registers
	logic [4:0] hidden_count_q;
	act_t       hid_act_q, out_act_q;

	// weight tables
	logic signed [15:0] w1_q [MAX_HIDDEN];
	logic signed [15:0] b1_q [MAX_HIDDEN];
	logic signed [15:0] w2_q [MAX_HIDDEN];
	logic signed [15:0] b2_q;

	// pipeline control: all stages advance together when the end is free
	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic signed [15:0] b2_s1, b2_s2, b2_s3;
	act_t oact_s1, oact_s2, oact_s3, oact_s4, oact_s5;
	logic [MAX_HIDDEN-1:0] use_mask;
	logic signed [31:0] prod [MAX_HIDDEN];
	logic [MAX_HIDDEN-1:0] hsat;
	logic signed [ACC_W-1:0] acc_s4;
	logic sat_s4;
	logic signed [15:0] pre_s5;
	logic sat_s5;
	out_item_t res_s6;

	assign en = !v_s6 || out_ch.ready;
	assign in_ch.ready = en;
	assign out_ch.valid = v_s6;
	assign out_ch.data = res_s6;

	always_comb begin
		for (int h = 0; h < MAX_HIDDEN; h++)
			use_mask[h] = 5'(h) < hidden_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hidden_count_q <= 5'd5;
			hid_act_q <= ACT_RELU;
			out_act_q <= ACT_LINEAR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HIDDEN_COUNT: hidden_count_q <= cfg_wdata;
				REG_HIDDEN_ACT:   hid_act_q <= act_t'(cfg_wdata[1:0]);
				REG_OUTPUT_ACT:   out_act_q <= act_t'(cfg_wdata[1:0]);
				default: ;
			endcase
		end
	end

	// parameter writes land at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int h = 0; h < MAX_HIDDEN; h++) begin
				w1_q[h] <= '0; b1_q[h] <= '0; w2_q[h] <= '0;
			end
			b2_q <= '0;
		end else if (in_ch.valid && en && in_ch.data.op) begin
			if (in_ch.data.param_index == IDX_OUTPUT_BIAS)
				b2_q <= in_ch.data.param_value;
			else if (in_ch.data.param_index[5:4] == 2'd0)
				w1_q[in_ch.data.param_index[HID_W-1:0]] <= in_ch.data.param_value;
			else if (in_ch.data.param_index[5:4] == 2'd1)
				b1_q[in_ch.data.param_index[HID_W-1:0]] <= in_ch.data.param_value;
			else if (in_ch.data.param_index[5:4] == 2'd2)
				w2_q[in_ch.data.param_index[HID_W-1:0]] <= in_ch.data.param_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid && !in_ch.data.op;
			v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5;
		end
	end

	// stages 1-3 live in the hidden lanes; the products are summed into stage 4
	mlp_hidden u_hidden (
		.clk(clk), .en(en), .x(in_ch.data.sample),
		.w1(w1_q), .b1(b1_q), .w2(w2_q), .use_mask(use_mask),
		.mode(hid_act_q), .prod(prod), .sat(hsat)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [ACC_W-1:0] sum;
			logic [16:0] fs;
			b2_s1 <= b2_q; oact_s1 <= out_act_q;
			b2_s2 <= b2_s1; oact_s2 <= oact_s1;
			b2_s3 <= b2_s2; oact_s3 <= oact_s2;
			oact_s4 <= oact_s3; oact_s5 <= oact_s4;
			// stage 4: adder tree of output products plus bias
			sum = ACC_W'(b2_s3) <<< 12;
			for (int h = 0; h < MAX_HIDDEN; h++) sum = sum + ACC_W'(prod[h]);
			acc_s4 <= sum;
			sat_s4 <= |hsat;
			// stage 5: floor and saturate
			fs = floor_sat(acc_s4);
			pre_s5 <= fs[16:1];
			sat_s5 <= sat_s4 | fs[0];
			// stage 6: output activation
			res_s6.prediction <= activate(pre_s5, oact_s5);
			res_s6.saturated <= sat_s5;
		end
	end

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed under stall");
	// write items never create results
	a_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready && in_ch.data.op |=> !v_s1)
		else $error("write item entered pipeline");
	// ready follows output side
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> out_ch.valid && !out_ch.ready)
		else $error("spurious stall");
endmodule

[sv/mlp_hidden.sv]
// ----------------------------------------------------------------------------
// mlp_hidden
// hidden lanes: product stage, floor/saturate/activate stage, output product
// ----------------------------------------------------------------------------
module mlp_hidden (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [15:0]           x,
	input  logic signed [15:0]           w1 [mlp_pkg::MAX_HIDDEN],
	input  logic signed [15:0]           b1 [mlp_pkg::MAX_HIDDEN],
	input  logic signed [15:0]           w2 [mlp_pkg::MAX_HIDDEN],
	input  logic [mlp_pkg::MAX_HIDDEN-1:0] use_mask,
	input  mlp_pkg::act_t                mode,
	output logic signed [31:0]           prod [mlp_pkg::MAX_HIDDEN],
	output logic [mlp_pkg::MAX_HIDDEN-1:0] sat
);
	import mlp_pkg::*;

	logic signed [ACC_W-1:0] pre_s1 [MAX_HIDDEN];
	logic signed [15:0]      w2_s1 [MAX_HIDDEN];
	logic [MAX_HIDDEN-1:0]   use_s1;
	logic signed [15:0]      act_s2 [MAX_HIDDEN];
	logic signed [15:0]      w2_s2 [MAX_HIDDEN];
	logic [MAX_HIDDEN-1:0]   sat_s2;
	logic signed [31:0]      prod_s3 [MAX_HIDDEN];
	logic [MAX_HIDDEN-1:0]   sat_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			use_s1 <= use_mask;
			for (int h = 0; h < MAX_HIDDEN; h++) begin
				pre_s1[h] <= ACC_W'(32'(w1[h]) * 32'(x)) + (ACC_W'(b1[h]) <<< 12);
				w2_s1[h]  <= w2[h];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int h = 0; h < MAX_HIDDEN; h++) begin
				logic [16:0] fs;
				fs = floor_sat(pre_s1[h]);
				act_s2[h] <= activate(fs[16:1], mode);
				sat_s2[h] <= fs[0] & use_s1[h];
				w2_s2[h]  <= use_s1[h] ? w2_s1[h] : 16'sd0;
			end
		end
	end

	// output weight products, registered ahead of the adder tree
	always_ff @(posedge clk) begin
		if (en) begin
			for (int h = 0; h < MAX_HIDDEN; h++)
				prod_s3[h] <= 32'(w2_s2[h]) * 32'(act_s2[h]);
			sat_s3 <= sat_s2;
		end
	end

	assign prod = prod_s3;
	assign sat = sat_s3;
endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the one-hidden-layer q4.12 network: a directed table
// of items, then random parameter loads and sample streams, checked against a
// predictor of the fixed-point inference under several idling phases
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mlp_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_wdata = '0;

	mlp_if #(.T(in_item_t))  in_ch ();
	mlp_if #(.T(out_item_t)) out_ch ();

	mlp_one_hidden_inference dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
	);

	always #4 clk = ~clk;

	// predictor state
	int unsigned       units_used;
	act_t              hid_mode, out_mode;
	int                w_hid [MAX_HIDDEN];
	int                b_hid [MAX_HIDDEN];
	int                w_out [MAX_HIDDEN];
	int                b_out;
	out_item_t         pending_predictions [$];

	int                mismatches = 0;
	int unsigned       cycle_count = 0;
	int unsigned       send_idle_pct = 0;
	int unsigned       stall_pct = 0;

	// stimulus table row: expected typed in only where marked
	typedef struct {
		in_item_t  item;
		bit        has_fixed;
		out_item_t fixed;
	} row_t;

	function automatic longint floor_by_4096(longint v);
		if (v >= 0)
			return v >>> 12;
		return -((-v + 4095) >>> 12);
	endfunction

	function automatic int clip16(longint v, ref bit clipped);
		if (v > 32767) begin
			clipped = 1'b1;
			return 32767;
		end
		if (v < -32768) begin
			clipped = 1'b1;
			return -32768;
		end
		return int'(v);
	endfunction

	function automatic int apply_act(int v, act_t mode);
		int mag, y;
		case (mode)
			ACT_RELU: return v < 0 ? 0 : v;
			ACT_SIGMOID: begin
				mag = v < 0 ? -v : v;
				if (mag >= 20480) y = 4096;
				else if (mag >= 9728) y = (mag >>> 5) + 3456;
				else if (mag >= 4096) y = (mag >>> 3) + 2560;
				else y = (mag >>> 2) + 2048;
				return v < 0 ? 4096 - y : y;
			end
			ACT_LINEAR: return v;
			default: return v >= 0 ? v : int'(floor_by_4096(longint'(v) * 410));
		endcase
	endfunction

	// updates the tables for a write item, returns the expected output of a sample
	function automatic bit infer_or_load(in_item_t it, output out_item_t res);
		int slot, x, pre_act, n;
		longint acc, pre;
		bit clipped;
		res = '0;
		clipped = 1'b0;
		if (it.op) begin
			slot = int'(it.param_index[3:0]);
			if (it.param_index == IDX_OUTPUT_BIAS) b_out = int'(it.param_value);
			else if (it.param_index < 16) w_hid[slot] = int'(it.param_value);
			else if (it.param_index < 32) b_hid[slot] = int'(it.param_value);
			else if (it.param_index < 48) w_out[slot] = int'(it.param_value);
			return 1'b0;
		end
		x = int'(it.sample);
		n = units_used > MAX_HIDDEN ? MAX_HIDDEN : units_used;
		acc = longint'(b_out) * 4096;
		for (int h = 0; h < n; h++) begin
			pre = longint'(w_hid[h]) * x + longint'(b_hid[h]) * 4096;
			pre_act = apply_act(clip16(floor_by_4096(pre), clipped), hid_mode);
			acc += longint'(w_out[h]) * pre_act;
		end
		res.prediction = 16'(apply_act(clip16(floor_by_4096(acc), clipped), out_mode));
		res.saturated = clipped;
		return 1'b1;
	endfunction

	// drive one item and queue its expected result; valid stays up afterwards
	task automatic send_item(in_item_t it, bit has_fixed = 1'b0,
			out_item_t fixed = '0);
		out_item_t res;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		if (infer_or_load(it, res)) begin
			// typed-in rows must agree with the predictor too
			if (has_fixed && res !== fixed) begin
				mismatches++;
				if (mismatches <= 10)
					$display("table row disagrees: typed %h predicted %h", fixed, res);
			end
			pending_predictions = {pending_predictions, (has_fixed ? fixed : res)};
		end
	endtask

	// register writes only while the pipeline is drained
	task automatic write_reg(logic [1:0] idx, logic [4:0] val);
		in_ch.valid <= 1'b0;
		while (pending_predictions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HIDDEN_COUNT: units_used = val;
			REG_HIDDEN_ACT: hid_mode = act_t'(val[1:0]);
			default: out_mode = act_t'(val[1:0]);
		endcase
	endtask

	function automatic in_item_t load_item(int idx, int val);
		in_item_t it;
		it = '0;
		it.op = 1'b1;
		it.param_index = 6'(idx);
		it.param_value = 16'(val);
		it.sample = 16'($urandom);
		return it;
	endfunction

	function automatic in_item_t sample_item(int x);
		in_item_t it;
		it = '0;
		it.sample = 16'(x);
		it.param_index = 6'($urandom);
		it.param_value = 16'($urandom);
		return it;
	endfunction

	// random sample value, mostly moderate so activations move between segments
	function automatic int rand_value();
		case ($urandom_range(3))
			0: return int'($signed(16'($urandom)));
			1: return $urandom_range(8192) - 4096;
			2: return $urandom_range(49152) - 24576;
			default: return $urandom_range(1) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
		endcase
	endfunction

	// output checker: receiver stalls at random
	always @(posedge clk) begin
		out_item_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_predictions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", out_ch.data);
			end else begin
				want = pending_predictions.pop_front();
				if (out_ch.data.prediction !== want.prediction ||
						out_ch.data.saturated !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected pred %0d sat %b, got pred %0d sat %b",
							want.prediction, want.saturated,
							out_ch.data.prediction, out_ch.data.saturated);
				end
			end
		end
		out_ch.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 400000) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		row_t table_rows [$];
		row_t r;
		int unsigned phase_pct [4][2];
		int wait_cycles;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b1;
		units_used = 5;
		hid_mode = ACT_RELU;
		out_mode = ACT_LINEAR;
		foreach (w_hid[i]) begin
			w_hid[i] = 0;
			b_hid[i] = 0;
			w_out[i] = 0;
		end
		b_out = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: zero tables after reset give zero predictions
		r.has_fixed = 1'b1;
		r.fixed = '0;
		r.item = sample_item(32767); table_rows = {table_rows, r};
		r.item = sample_item(-32768); table_rows = {table_rows, r};
		r.has_fixed = 1'b0;
		// output bias alone, extremes
		r.item = load_item(48, 32767); table_rows = {table_rows, r};
		r.has_fixed = 1'b1;
		r.fixed = '{prediction: 16'sd32767, saturated: 1'b0};
		r.item = sample_item(0); table_rows = {table_rows, r};
		r.has_fixed = 1'b0;
		r.item = load_item(48, -32768); table_rows = {table_rows, r};
		r.has_fixed = 1'b1;
		r.fixed = '{prediction: -16'sd32768, saturated: 1'b0};
		r.item = sample_item(5); table_rows = {table_rows, r};
		r.has_fixed = 1'b0;
		// unit 0 weights at extremes force saturation of the hidden sum
		r.item = load_item(0, 32767); table_rows = {table_rows, r};
		r.item = load_item(16, 32767); table_rows = {table_rows, r};
		r.item = load_item(32, -32768); table_rows = {table_rows, r};
		r.item = load_item(48, 0); table_rows = {table_rows, r};
		r.item = sample_item(32767); table_rows = {table_rows, r};
		r.item = sample_item(-32768); table_rows = {table_rows, r};
		// out-of-range indexes are ignored
		r.item = load_item(49, 1234); table_rows = {table_rows, r};
		r.item = load_item(63, -1); table_rows = {table_rows, r};
		r.item = sample_item(4096); table_rows = {table_rows, r};
		// unit 4 is the last one in use at reset
		r.item = load_item(4, -4096); table_rows = {table_rows, r};
		r.item = load_item(20, 100); table_rows = {table_rows, r};
		r.item = load_item(36, 4096); table_rows = {table_rows, r};
		r.item = load_item(15, 2000); table_rows = {table_rows, r};
		r.item = load_item(47, 3000); table_rows = {table_rows, r};
		r.item = sample_item(-4096); table_rows = {table_rows, r};
		r.item = sample_item(9728); table_rows = {table_rows, r};
		foreach (table_rows[i])
			send_item(table_rows[i].item, table_rows[i].has_fixed, table_rows[i].fixed);

		// zero units: output bias alone
		write_reg(REG_HIDDEN_COUNT, 5'd0);
		send_item(sample_item(12345));
		write_reg(REG_HIDDEN_COUNT, 5'd31);
		send_item(sample_item(-777));

		phase_pct = '{'{0, 0}, '{52, 0}, '{0, 52}, '{25, 25}};
		for (int ph = 0; ph < 12; ph++) begin
			send_idle_pct = phase_pct[ph % 4][0];
			stall_pct = phase_pct[ph % 4][1];
			// each phase has its own setting, extremes included
			write_reg(REG_HIDDEN_COUNT, ph == 0 ? 5'd1 : ph == 1 ? 5'd16 :
				ph == 2 ? 5'd0 : 5'($urandom_range(31)));
			write_reg(REG_HIDDEN_ACT, 5'(ph % 4));
			write_reg(REG_OUTPUT_ACT, 5'((ph / 4 + ph) % 4));
			for (int k = 0; k < 110; k++) begin
				if ($urandom_range(99) < 30) begin
					// mostly useful slots, some out of range
					if ($urandom_range(9) == 0)
						send_item(load_item($urandom_range(63), int'($signed(16'($urandom)))));
					else
						send_item(load_item($urandom_range(48),
							$urandom_range(1) ? rand_value() : $urandom_range(2048) - 1024));
				end else
					send_item(sample_item(rand_value()));
			end
		end

		in_ch.valid <= 1'b0;
		wait_cycles = 0;
		while (pending_predictions.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_predictions.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

[mlp_one_hidden_inference.f]
sv/mlp_pkg.sv
sv/mlp_if.sv
sv/mlp_hidden.sv
sv/mlp_one_hidden_inference.sv
tb/testbench.sv
